// ===== hdl/kpt_pkg.sv =====
// shared types and constants for the keyed policy table
// no dependencies; imported by keyed_policy_table_top
package kpt_pkg;

    localparam int SUBJ_W             = 32;
    localparam int DATA_W             = 64;
    localparam int DEF_TABLE_ENTRIES  = 32;
    localparam int DEF_POLICY_BITS    = 64;

    typedef enum logic [1:0] {
        ACT_APPLY   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_GET     = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_INVALID  = 2'd1,
        STAT_NOSPACE  = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_RESP
    } t_state;

endpackage

// ===== hdl/kpt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; used by keyed_policy_table_top for the entry store
module kpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/keyed_policy_table_top.sv =====
// keyed policy table: a request that reaches the table is scanned through the entry ram
// (one read per cycle through the entry ram port, one compare a cycle); a match at entry k
// ends the scan early; an invalid request skips the scan and goes straight to the result.
// one request at a time: new requests stall until the result is taken.
// synchronous active-low reset clears all entry valid bits and the sequencer at once; the entry
// ram is not cleared, a never-written entry is masked by its valid bit. depends on kpt_pkg, kpt_ram
module keyed_policy_table_top #(
    parameter int TABLE_ENTRIES = kpt_pkg::DEF_TABLE_ENTRIES,
    parameter int POLICY_BITS   = kpt_pkg::DEF_POLICY_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_action,
    input  logic [kpt_pkg::SUBJ_W-1:0] i_subject,
    input  logic [kpt_pkg::DATA_W-1:0] i_policy_data,
    input  logic                       i_policy_named,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [kpt_pkg::DATA_W-1:0] o_policy_out
);

    import kpt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ENT_W = SUBJ_W + POLICY_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // sequencer and request registers
    t_state                  r_state, n_state;
    logic [1:0]              r_action, n_action;
    logic [SUBJ_W-1:0]       r_subject, n_subject;
    logic [POLICY_BITS-1:0]  r_data, n_data;

    // scan pipeline: read issue stage and compare stage
    logic [IDX_W-1:0]        r_addr, n_addr;
    logic                    r_issue_more, n_issue_more;
    logic                    r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]        r_cmp_idx, n_cmp_idx;

    // scan findings
    logic                    r_found, n_found;
    logic [IDX_W-1:0]        r_hit_idx, n_hit_idx;
    logic [POLICY_BITS-1:0]  r_hit_pol, n_hit_pol;
    logic                    r_free_found, n_free_found;
    logic [IDX_W-1:0]        r_free_idx, n_free_idx;

    // entry valid bits, cleared by reset
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;

    // result register
    t_status                 r_status, n_status;
    logic [POLICY_BITS-1:0]  r_pol, n_pol;

    // ram side
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [ENT_W-1:0]        ram_rdata;
    logic [SUBJ_W-1:0]       rd_subject;
    logic [POLICY_BITS-1:0]  rd_policy;

    logic                    in_accept;
    logic                    req_invalid;
    logic                    cmp_hit;
    logic                    cmp_last;

    assign in_accept = i_valid && !o_stall;

    // zero subject, unused action code, or apply without a name
    assign req_invalid = (i_subject == '0)
                      || ((i_action != ACT_APPLY) && (i_action != ACT_RELEASE)
                          && (i_action != ACT_GET))
                      || ((i_action == ACT_APPLY) && !i_policy_named);

    assign rd_subject = ram_rdata[POLICY_BITS +: SUBJ_W];
    assign rd_policy  = ram_rdata[POLICY_BITS-1:0];

    // the shared compare: one entry per cycle, first valid match wins
    assign cmp_hit  = r_cmp_vld && r_valid[r_cmp_idx] && (rd_subject == r_subject);
    assign cmp_last = r_cmp_vld && (r_cmp_idx == LAST_IDX);

    kpt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = req_invalid ? S_RESP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (cmp_hit || cmp_last) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_action     = r_action;
        n_subject    = r_subject;
        n_data       = r_data;
        n_addr       = r_addr;
        n_issue_more = r_issue_more;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_found      = r_found;
        n_hit_idx    = r_hit_idx;
        n_hit_pol    = r_hit_pol;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_status     = r_status;
        n_pol        = r_pol;
        ram_we       = 1'b0;
        ram_waddr    = r_hit_idx;
        ram_wdata    = {r_subject, r_data};
        o_stall      = (r_state != S_IDLE);
        o_valid      = (r_state == S_RESP);

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_action     = i_action;
                    n_subject    = i_subject;
                    n_data       = i_policy_data[POLICY_BITS-1:0];
                    n_addr       = '0;
                    n_issue_more = 1'b1;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_status     = STAT_INVALID;
                    n_pol        = '0;
                end
            end
            S_SCAN: begin
                // issue stage
                if (r_issue_more) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_addr;
                    if (r_addr == LAST_IDX) begin
                        n_issue_more = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                // compare stage
                if (cmp_hit) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_hit_pol = rd_policy;
                    n_cmp_vld = 1'b0;
                end else if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                if (cmp_last) begin
                    n_cmp_vld = 1'b0;
                end
            end
            S_ACT: begin
                n_pol = '0;
                case (r_action)
                    ACT_APPLY: begin
                        if (r_found || r_free_found) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_found ? r_hit_idx : r_free_idx;
                            n_valid[ram_waddr] = 1'b1;
                            n_status  = STAT_OK;
                        end else begin
                            n_status  = STAT_NOSPACE;
                        end
                    end
                    ACT_RELEASE: begin
                        if (r_found) begin
                            n_valid[r_hit_idx] = 1'b0;
                            n_status = STAT_OK;
                        end else begin
                            n_status = STAT_NOTFOUND;
                        end
                    end
                    ACT_GET: begin
                        if (r_found) begin
                            n_pol    = r_hit_pol;
                            n_status = STAT_OK;
                        end else begin
                            n_status = STAT_NOTFOUND;
                        end
                    end
                    default: begin
                        n_status = STAT_INVALID;
                    end
                endcase
            end
            S_RESP: begin
                // result held until taken
            end
            default: begin
                n_status = STAT_INVALID;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_subject    <= n_subject;
        r_data       <= n_data;
        r_addr       <= n_addr;
        r_issue_more <= n_issue_more;
        r_cmp_idx    <= n_cmp_idx;
        r_found      <= n_found;
        r_hit_idx    <= n_hit_idx;
        r_hit_pol    <= n_hit_pol;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_status     <= n_status;
        r_pol        <= n_pol;
    end

    assign o_status     = r_status;
    assign o_policy_out = DATA_W'(r_pol);

    // a pending result blocks new requests
    a_resp_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request accepted while result pending");

    // policy word only carried by a successful result
    a_pol_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_OK)) |-> (o_policy_out == '0))
        else $error("nonzero policy on failed result");

    // an apply write marks its entry valid
    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_valid[$past(ram_waddr)])
        else $error("written entry not valid");

    // scan always ends in the action step
    a_scan_to_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (cmp_hit || cmp_last)) |=> (r_state == S_ACT))
        else $error("scan did not finish into action step");

endmodule
